### rtl/esd_pkg.sv
package esd_pkg;

  localparam int MAGIC_SLOTS = 6;
  localparam int BYTE_W      = 8;
  localparam int VALUE_W     = 13;
  localparam int USED_W      = 3;
  localparam int CHARS_W     = 48;
  localparam int COUNT_W     = 3;
  localparam int CFG_IDX_W   = 2;

  localparam logic [COUNT_W-1:0] MAGIC_SLOTS_N = COUNT_W'(MAGIC_SLOTS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC_CHARS = 2'd0,
    CFG_MAGIC_COUNT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [CHARS_W-1:0] chars;
    logic [COUNT_W-1:0] count;
  } magic_cfg_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [USED_W-1:0]         consumed;
  } decode_t;

  // Returns {is_hex, digit}.
  function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] b);
    logic [4:0] r;
    r = 5'b0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // Returns {is_octal, digit}.
  function automatic logic [3:0] oct_digit(input logic [BYTE_W-1:0] b);
    logic [3:0] r;
    r = 4'b0;
    if (b >= 8'h30 && b <= 8'h37) begin
      r = {1'b1, 3'(b - 8'h30)};
    end
    return r;
  endfunction

endpackage

### rtl/esd_decode.sv
module esd_decode import esd_pkg::*; (
  input  logic [BYTE_W-1:0] first_byte,
  input  logic [BYTE_W-1:0] second_byte,
  input  logic [BYTE_W-1:0] third_byte,
  input  logic [BYTE_W-1:0] fourth_byte,
  input  magic_cfg_t        magic,
  output decode_t           result
);

  logic [BYTE_W-1:0]  lower;
  logic               ctl_hit;
  logic [BYTE_W-1:0]  ctl_code;
  logic [4:0]         h1, h2, h3;
  logic [3:0]         o0, o1, o2;
  logic [11:0]        hex_val;
  logic [USED_W-1:0]  hex_used;
  logic [8:0]         oct_val;
  logic [USED_W-1:0]  oct_used;
  logic [COUNT_W-1:0] slots;
  logic               magic_hit;
  logic [2:0]         magic_slot;

  always_comb begin
    lower = first_byte;
    if (first_byte >= 8'h41 && first_byte <= 8'h5a) begin
      lower = first_byte + 8'd32;
    end
    ctl_hit  = 1'b1;
    ctl_code = '0;
    unique case (lower)
      8'h61: ctl_code = 8'd7;
      8'h62: ctl_code = 8'd8;
      8'h66: ctl_code = 8'd12;
      8'h6e: ctl_code = 8'd10;
      8'h72: ctl_code = 8'd13;
      8'h74: ctl_code = 8'd9;
      8'h76: ctl_code = 8'd11;
      default: ctl_hit = 1'b0;
    endcase
  end

  // Hex digits run from the second byte and stop at the first non-digit.
  always_comb begin
    h1 = hex_digit(second_byte);
    h2 = hex_digit(third_byte);
    h3 = hex_digit(fourth_byte);
    if (h1[4] && h2[4] && h3[4]) begin
      hex_val  = {h1[3:0], h2[3:0], h3[3:0]};
      hex_used = 3'd4;
    end else if (h1[4] && h2[4]) begin
      hex_val  = {4'b0, h1[3:0], h2[3:0]};
      hex_used = 3'd3;
    end else if (h1[4]) begin
      hex_val  = {8'b0, h1[3:0]};
      hex_used = 3'd2;
    end else begin
      hex_val  = '0;
      hex_used = 3'd1;
    end
  end

  // The first byte is known to be octal when this path is chosen.
  always_comb begin
    o0 = oct_digit(first_byte);
    o1 = oct_digit(second_byte);
    o2 = oct_digit(third_byte);
    if (o1[3] && o2[3]) begin
      oct_val  = {o0[2:0], o1[2:0], o2[2:0]};
      oct_used = 3'd3;
    end else if (o1[3]) begin
      oct_val  = {3'b0, o0[2:0], o1[2:0]};
      oct_used = 3'd2;
    end else begin
      oct_val  = {6'b0, o0[2:0]};
      oct_used = 3'd1;
    end
  end

  // Scan from the top slot down so that the lowest matching slot wins.
  always_comb begin
    slots      = (magic.count > MAGIC_SLOTS_N) ? MAGIC_SLOTS_N : magic.count;
    magic_hit  = 1'b0;
    magic_slot = '0;
    for (int i = MAGIC_SLOTS - 1; i >= 0; i--) begin
      if (3'(i) < slots && magic.chars[BYTE_W*i +: BYTE_W] == first_byte) begin
        magic_hit  = 1'b1;
        magic_slot = 3'(i);
      end
    end
  end

  always_comb begin
    result.consumed = 3'd1;
    if (first_byte == 8'h00) begin
      result.value = '0;
    end else if (ctl_hit) begin
      result.value = VALUE_W'(ctl_code);
    end else if (first_byte == 8'h78) begin
      result.value    = VALUE_W'(hex_val);
      result.consumed = hex_used;
    end else if (first_byte == 8'h38 || first_byte == 8'h39) begin
      result.value = VALUE_W'(first_byte);
    end else if (o0[3]) begin
      result.value    = VALUE_W'(oct_val);
      result.consumed = oct_used;
    end else if (magic_hit) begin
      // Minus one minus the slot is the complement of the slot.
      result.value = ~VALUE_W'(magic_slot);
    end else begin
      result.value = VALUE_W'(first_byte);
    end
  end

endmodule

### rtl/escape_sequence_decode_top.sv
// An accepted input transaction passes through the input register and then the result register to the output.
// Throughput: one escape per cycle; an input register and a result register form a
// two-stage pipeline that advances whenever the output is not stalled.
// Reset (synchronous, active high) empties both stages and clears the magic
// registers to zero.
module escape_sequence_decode_top import esd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [BYTE_W-1:0]         first_byte,
  input  logic [BYTE_W-1:0]         second_byte,
  input  logic [BYTE_W-1:0]         third_byte,
  input  logic [BYTE_W-1:0]         fourth_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] value,
  output logic [USED_W-1:0]         consumed,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CHARS_W-1:0]        cfg_data
);

  magic_cfg_t        magic;
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_b0, s1_b1, s1_b2, s1_b3;
  logic              s1_en, s2_en;
  decode_t           dec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MAGIC_CHARS) begin
        magic.chars <= cfg_data;
      end else if (cfg_index == CFG_MAGIC_COUNT) begin
        magic.count <= cfg_data[COUNT_W-1:0];
      end
    end
  end

  assign s2_en    = !out_valid || !out_stall;
  assign s1_en    = !s1_valid || s2_en;
  assign in_stall = !s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_b0 <= first_byte;
      s1_b1 <= second_byte;
      s1_b2 <= third_byte;
      s1_b3 <= fourth_byte;
    end
  end

  esd_decode u_decode (
    .first_byte  (s1_b0),
    .second_byte (s1_b1),
    .third_byte  (s1_b2),
    .fourth_byte (s1_b3),
    .magic       (magic),
    .result      (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid) begin
      value    <= dec.value;
      consumed <= dec.consumed;
    end
  end

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_consumed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (consumed >= 3'd1 && consumed <= 3'd4))
    else $error("consumed out of range");

  a_magic_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && value < 0) |->
      (consumed == 3'd1 && value >= -VALUE_W'(MAGIC_SLOTS)))
    else $error("negative value is not a magic slot");

endmodule

### bench/escape_sequence_decode_top_test.sv
`timescale 1ns / 1ps

module escape_sequence_decode_top_test import esd_pkg::*;;

  typedef logic [3:0][BYTE_W-1:0] window_t;

  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEMS_PER_PHASE = 110;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  class escape_scoreboard;
    logic [CHARS_W-1:0] magic_chars;
    logic [COUNT_W-1:0] magic_count;
    decode_t            expected_decodes[$];
    int                 mismatch_count;

    function new();
      magic_chars = '0;
      magic_count = '0;
      mismatch_count = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CHARS_W-1:0] data);
      case (idx)
        CFG_MAGIC_CHARS: magic_chars = data;
        CFG_MAGIC_COUNT: magic_count = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function decode_t decode_window(window_t win);
      logic [BYTE_W-1:0] lower;
      int      v;
      int      used;
      int      n;
      int      d;
      bit      done;
      decode_t r;
      v = 0;
      used = 1;
      done = 1'b0;
      lower = win[0];
      if (win[0] >= "A" && win[0] <= "Z") begin
        lower = win[0] + 8'd32;
      end
      if (win[0] == 8'h00) begin
        done = 1'b1;
      end else begin
        done = 1'b1;
        case (lower)
          "a": v = 7;
          "b": v = 8;
          "f": v = 12;
          "n": v = 10;
          "r": v = 13;
          "t": v = 9;
          "v": v = 11;
          default: done = 1'b0;
        endcase
      end
      if (!done && win[0] == "x") begin
        for (int i = 1; i < 4; i++) begin
          d = -1;
          if (win[i] >= "0" && win[i] <= "9") begin
            d = win[i] - "0";
          end else if (win[i] >= "a" && win[i] <= "f") begin
            d = win[i] - "a" + 10;
          end else if (win[i] >= "A" && win[i] <= "F") begin
            d = win[i] - "A" + 10;
          end
          if (d < 0) break;
          v = (v << 4) | d;
          used++;
        end
        done = 1'b1;
      end
      if (!done && win[0] >= "0" && win[0] <= "9") begin
        if (win[0] >= "8") begin
          v = win[0];
        end else begin
          // Octal digits run from the first byte and stop after three.
          used = 0;
          for (int i = 0; i < 3; i++) begin
            if (win[i] < "0" || win[i] > "7") break;
            v = (v << 3) | (win[i] - "0");
            used++;
          end
        end
        done = 1'b1;
      end
      if (!done) begin
        n = (magic_count > MAGIC_SLOTS) ? MAGIC_SLOTS : magic_count;
        for (int i = 0; i < n; i++) begin
          if (magic_chars[8*i +: 8] == win[0]) begin
            v = -1 - i;
            done = 1'b1;
            break;
          end
        end
      end
      if (!done) begin
        v = win[0];
      end
      r.value = VALUE_W'(v);
      r.consumed = USED_W'(used);
      return r;
    endfunction

    function void note_input(window_t win);
      expected_decodes.push_back(decode_window(win));
    endfunction

    task check_result(logic signed [VALUE_W-1:0] got_value, logic [USED_W-1:0] got_consumed);
      decode_t exp;
      if (expected_decodes.size() == 0) begin
        report($sformatf("result value %0d consumed %0d with nothing outstanding",
                         got_value, got_consumed));
      end else begin
        exp = expected_decodes.pop_front();
        if (got_value !== exp.value) begin
          report($sformatf("value %0d, expected %0d", got_value, exp.value));
        end
        if (got_consumed !== exp.consumed) begin
          report($sformatf("consumed %0d, expected %0d", got_consumed, exp.consumed));
        end
      end
    endtask

    function int pending();
      return expected_decodes.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [BYTE_W-1:0]         first_byte;
  logic [BYTE_W-1:0]         second_byte;
  logic [BYTE_W-1:0]         third_byte;
  logic [BYTE_W-1:0]         fourth_byte;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [VALUE_W-1:0] value;
  logic [USED_W-1:0]         consumed;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CHARS_W-1:0]        cfg_data;

  escape_scoreboard sb;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  escape_sequence_decode_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .first_byte  (first_byte),
    .second_byte (second_byte),
    .third_byte  (third_byte),
    .fourth_byte (fourth_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .consumed    (consumed),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: check every accepted transaction, then pick the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(value, consumed);
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task send_escape(logic [BYTE_W-1:0] b0, logic [BYTE_W-1:0] b1,
                   logic [BYTE_W-1:0] b2, logic [BYTE_W-1:0] b3);
    window_t win;
    win = {b3, b2, b1, b0};
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    first_byte  <= b0;
    second_byte <= b1;
    third_byte  <= b2;
    fourth_byte <= b3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(win);
  endtask

  // The write channel returns to idle after each transaction.
  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CHARS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only with the pipeline empty.
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task set_magic(logic [CHARS_W-1:0] chars, logic [COUNT_W-1:0] count);
    drain();
    write_reg(CFG_MAGIC_CHARS, chars);
    write_reg(CFG_MAGIC_COUNT, CHARS_W'(count));
  endtask

  // Mostly well-formed escapes with random content; the tail bytes are often NUL
  // to mimic the end of a string.
  function automatic window_t random_escape();
    window_t win;
    string   ctl;
    string   hex;
    string   oct;
    int      kind;
    int      n;
    ctl = "abfnrtvABFNRTV";
    hex = "0123456789abcdefABCDEF";
    oct = "01234567";
    for (int i = 0; i < 4; i++) begin
      win[i] = ($urandom_range(3) == 0) ? 8'h00 : BYTE_W'($urandom_range(255));
    end
    kind = $urandom_range(99);
    if (kind < 12) begin
      for (int i = 0; i < 4; i++) win[i] = BYTE_W'($urandom_range(255));
    end else if (kind < 20) begin
      win[0] = 8'h00;
    end else if (kind < 38) begin
      win[0] = ctl[$urandom_range(13)];
    end else if (kind < 58) begin
      win[0] = "x";
      n = $urandom_range(3);
      for (int i = 1; i <= n; i++) win[i] = hex[$urandom_range(21)];
    end else if (kind < 78) begin
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) win[i] = oct[$urandom_range(7)];
    end else if (kind < 83) begin
      win[0] = $urandom_range(1) ? "9" : "8";
    end else if (kind < 93) begin
      win[0] = sb.magic_chars[8*$urandom_range(MAGIC_SLOTS-1) +: 8];
    end else begin
      win[0] = $urandom_range(1) ? "X" : BYTE_W'($urandom_range(126, 33));
    end
    return win;
  endfunction

  initial begin
    window_t              win;
    logic [CHARS_W-1:0]   chars;
    logic [CHARS_W-1:0]   printable;
    sb = new();
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    first_byte  <= '0;
    second_byte <= '0;
    third_byte  <= '0;
    fourth_byte <= '0;
    out_stall   <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_MAGIC_CHARS;
    cfg_data    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Slots 5..0: 'Q', NUL, 'n', '$', '$', '#'.
    set_magic({8'h51, 8'h00, 8'h6e, 8'h24, 8'h24, 8'h23}, 3'd6);
    send_escape(8'h00, "A", "B", "C");
    send_escape("a", 8'h00, 8'h00, 8'h00);
    send_escape("B", "1", "2", "3");
    send_escape("f", "x", "y", "z");
    send_escape("N", 8'h00, 8'h00, 8'h00);
    send_escape("r", "7", "7", "7");
    send_escape("T", 8'hff, 8'hff, 8'hff);
    send_escape("v", 8'h00, 8'h00, 8'h00);
    send_escape("V", "a", "b", "c");
    send_escape("x", "g", 8'h00, 8'h00);
    send_escape("x", "F", "f", "0");
    send_escape("x", "A", "7", "z");
    send_escape("x", "9", "9", "9");
    send_escape("X", "1", "2", "3");
    send_escape("7", "7", "7", "7");
    send_escape("0", 8'h00, 8'h00, 8'h00);
    send_escape("1", "2", "8", "0");
    send_escape("8", "1", "2", "3");
    send_escape("9", 8'h00, 8'h00, 8'h00);
    send_escape("#", 8'h00, 8'h00, 8'h00);
    send_escape("$", "$", "$", "$");
    send_escape("Q", 8'h00, 8'h00, 8'h00);
    send_escape(8'hff, 8'hff, 8'hff, 8'hff);
    send_escape(8'h80, 8'h00, 8'h00, 8'h00);

    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < MAGIC_SLOTS; i++) begin
        printable[8*i +: 8] = BYTE_W'($urandom_range(126, 33));
      end
      chars = CHARS_W'({$urandom, $urandom});
      case (phase)
        0: set_magic(chars, 3'd7);
        1: set_magic(chars, 3'd0);
        2: begin
          set_magic({CHARS_W{1'b1}}, 3'd1);
          // Unused indexes must leave both registers alone.
          write_reg(CFG_SPARE_2, chars);
          write_reg(CFG_SPARE_3, ~chars);
        end
        3: set_magic('0, 3'd3);
        4: set_magic(chars, COUNT_W'($urandom_range(6, 1)));
        default: set_magic(printable, 3'd6);
      endcase
      if (phase < 2) begin
        send_gap_pct = 14;
        recv_stall_pct = 82;
      end else if (phase < 4) begin
        send_gap_pct = 82;
        recv_stall_pct = 14;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        win = random_escape();
        send_escape(win[0], win[1], win[2], win[3]);
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
